// File: sv/rsrv_pkg.sv
package rsrv_pkg;

  localparam int TIME_W  = 34;
  localparam int SIGNED_W = 38;
  localparam int COUNT_W = 16;
  localparam int VEL_W   = 21;
  localparam int MAG_W   = 17;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam int TAYLOR_TERMS = 13;

  // (2n)(2n+1) for n = 1 .. 13
  localparam logic [9:0] TAYLOR_DIV [TAYLOR_TERMS] = '{
    10'd6, 10'd20, 10'd42, 10'd72, 10'd110, 10'd156, 10'd210,
    10'd272, 10'd342, 10'd420, 10'd506, 10'd600, 10'd702
  };

  // register indexes on the config port
  localparam logic [2:0] REG_PEAK_VELOCITY  = 3'd0;
  localparam logic [2:0] REG_PHASE_RATE     = 3'd1;
  localparam logic [2:0] REG_RAMP_TIME      = 3'd2;
  localparam logic [2:0] REG_CONSTANT_TIME  = 3'd3;
  localparam logic [2:0] REG_CYCLE_LIMIT    = 3'd4;
  localparam logic [2:0] REG_SWEEP_DISTANCE = 3'd5;
  localparam logic [2:0] REG_RAMP_DISTANCE  = 3'd6;

  typedef struct packed {
    logic        [19:0] peak_velocity;
    logic        [31:0] phase_rate;
    logic        [31:0] ramp_time;
    logic signed [31:0] constant_time;
    logic        [15:0] cycle_limit;
    logic        [23:0] sweep_distance;
    logic        [23:0] ramp_distance;
  } cfg_t;

  typedef enum logic [1:0] {
    KIND_SINE,
    KIND_POS,
    KIND_NEG,
    KIND_ZERO
  } kind_t;

  typedef struct packed {
    kind_t               kind;
    logic [31:0]         arg;
    logic                finished;
    logic [COUNT_W-1:0]  count;
  } entry_t;

endpackage

// File: sv/rsrv_front.sv
module rsrv_front (
  input  logic              clk,
  input  logic              rst,
  input  rsrv_pkg::cfg_t    cfg,
  input  logic              item_valid,
  output logic              item_ready,
  input  logic              action,
  input  logic [15:0]       period_us,
  output logic              push_valid,
  input  logic              push_ready,
  output rsrv_pkg::entry_t  push_data
);

  localparam int TW = rsrv_pkg::TIME_W;
  localparam int SW = rsrv_pkg::SIGNED_W;
  localparam int CW = rsrv_pkg::COUNT_W;

  typedef enum logic [1:0] {F_IDLE, F_CLASSIFY, F_PUSH} state_t;

  state_t               state;
  logic [TW-1:0]        elapsed_time;
  logic [CW-1:0]        sweep_count;
  logic                 restart;

  // segment limits, refreshed every cycle from the registers
  logic signed [SW-1:0] lim_a;
  logic signed [SW-1:0] lim_ca;
  logic signed [SW-1:0] lim_c3a;
  logic signed [SW-1:0] lim_3a2c;
  logic signed [SW-1:0] total;
  logic signed [SW-1:0] c_ext;
  logic signed [SW-1:0] c_two;

  logic signed [SW-1:0] a_s;
  logic signed [SW-1:0] c_s;
  logic signed [SW-1:0] a3_s;

  logic [TW:0]          sum;
  logic [TW-1:0]        sat_time;
  logic signed [SW-1:0] t;
  logic signed [SW-1:0] arg_full;
  logic signed [SW-1:0] wrap_diff;
  rsrv_pkg::kind_t      kind;
  logic                 wrap;
  logic [TW-1:0]        elapsed_next;
  logic [CW-1:0]        sweep_count_next;
  logic                 fin;

  assign a_s  = SW'($signed({1'b0, cfg.ramp_time}));
  assign c_s  = SW'(cfg.constant_time);
  assign a3_s = a_s + (a_s <<< 1);

  always_ff @(posedge clk) begin
    lim_a    <= a_s;
    lim_ca   <= c_s + a_s;
    lim_c3a  <= c_s + a3_s;
    lim_3a2c <= a3_s + (c_s <<< 1);
    total    <= (a_s <<< 2) + (c_s <<< 1);
    c_ext    <= c_s;
    c_two    <= c_s <<< 1;
  end

  assign sum      = {1'b0, elapsed_time} + (TW+1)'(period_us);
  assign sat_time = sum[TW] ? '1 : sum[TW-1:0];

  assign t = SW'($signed({1'b0, elapsed_time}));

  always_comb begin
    kind     = rsrv_pkg::KIND_SINE;
    arg_full = t;
    priority if (restart) begin
      kind = rsrv_pkg::KIND_ZERO;
    end else if (t <= lim_a) begin
      kind = rsrv_pkg::KIND_SINE;
    end else if (t <= lim_ca) begin
      kind = rsrv_pkg::KIND_POS;
    end else if (t <= lim_c3a) begin
      arg_full = t - c_ext;
    end else if (t <= lim_3a2c) begin
      kind = rsrv_pkg::KIND_NEG;
    end else begin
      arg_full = t - c_two;
    end
  end

  assign wrap_diff = t - total;
  assign wrap      = !restart && (t >= total);

  always_comb begin
    elapsed_next     = elapsed_time;
    sweep_count_next = sweep_count;
    if (wrap) begin
      elapsed_next = (total <= 0) ? '0 : wrap_diff[TW-1:0];
      if (sweep_count != '1) begin
        sweep_count_next = sweep_count + 1'b1;
      end
    end
  end

  assign fin = (cfg.sweep_distance <= cfg.ramp_distance) ||
               (sweep_count_next >= cfg.cycle_limit);

  assign item_ready = (state == F_IDLE);
  assign push_valid = (state == F_PUSH);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= F_IDLE;
      elapsed_time <= '0;
      sweep_count  <= '0;
      restart      <= 1'b0;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (item_valid) begin
            restart      <= action;
            elapsed_time <= action ? '0 : sat_time;
            state        <= F_CLASSIFY;
          end
        end
        F_CLASSIFY: begin
          push_data.kind     <= kind;
          push_data.arg      <= arg_full[31:0];
          push_data.finished <= fin;
          push_data.count    <= sweep_count_next;
          elapsed_time       <= elapsed_next;
          sweep_count        <= sweep_count_next;
          state              <= F_PUSH;
        end
        F_PUSH: begin
          if (push_ready) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

// File: sv/rsrv_queue.sv
module rsrv_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  output logic              push_ready,
  input  rsrv_pkg::entry_t  push_data,
  output logic              pop_valid,
  input  logic              pop_ready,
  output rsrv_pkg::entry_t  pop_data
);

  rsrv_pkg::entry_t slot [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       fill;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (fill != 2'd2);
  assign pop_valid  = (fill != 2'd0);
  assign pop_data   = slot[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      unique case ({do_push, do_pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// File: sv/rsrv_back.sv
module rsrv_back #(
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  logic                            clk,
  input  logic                            rst,
  input  rsrv_pkg::cfg_t                  cfg,
  input  logic                            pop_valid,
  output logic                            pop_ready,
  input  rsrv_pkg::entry_t                pop_data,
  output logic                            result_valid,
  input  logic                            result_ready,
  output logic signed [rsrv_pkg::VEL_W-1:0] velocity_x,
  output logic                            finished,
  output logic [rsrv_pkg::COUNT_W-1:0]    sweeps_done
);

  localparam int IDX_W  = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int PROD_W = 30 + IDX_W;
  localparam int MAG_W  = rsrv_pkg::MAG_W;
  localparam int VEL_W  = rsrv_pkg::VEL_W;
  localparam int SCL_W  = 20 + MAG_W;

  typedef enum logic [2:0] {B_IDLE, B_PHASE, B_INDEX, B_READ, B_SCALE, B_DONE} state_t;

  // quarter-wave entry k by integer taylor series in q30, rounded to q16
  function automatic logic [MAG_W-1:0] sine_entry(input int unsigned k);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] acc;
    logic signed [63:0] q16;
    x    = (rsrv_pkg::HALF_PI_Q30 * 64'(k)) / SINE_TABLE_DEPTH;
    x2   = (x * x) >> 30;
    term = x;
    acc  = $signed(x);
    for (int n = 1; n <= rsrv_pkg::TAYLOR_TERMS; n++) begin
      term = ((term * x2) >> 30) / 64'(rsrv_pkg::TAYLOR_DIV[n-1]);
      if (n % 2 == 1) begin
        acc = acc - $signed(term);
      end else begin
        acc = acc + $signed(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    q16 = (acc + 64'sd8192) >>> 14;
    if (q16 > 64'sd65536) begin
      q16 = 64'sd65536;
    end
    return q16[MAG_W-1:0];
  endfunction

  logic [MAG_W-1:0] quarter_wave [SINE_TABLE_DEPTH+1];

  for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_wave
    assign quarter_wave[k] = sine_entry(k);
  end

  state_t              state;
  rsrv_pkg::entry_t    cur;
  logic [31:0]         phase;
  logic [1:0]          quadrant;
  logic [IDX_W-1:0]    idx;
  logic [MAG_W-1:0]    mag;
  logic [SCL_W-1:0]    scaled;

  logic [PROD_W-1:0]   idx_prod;
  logic [IDX_W-1:0]    addr;
  logic [SCL_W-1:0]    rounded;
  logic [VEL_W-1:0]    sine_mag;
  logic [VEL_W-1:0]    peak_ext;
  logic signed [VEL_W-1:0] vel_sel;
  logic                out_free;

  assign idx_prod = PROD_W'(phase[29:0]) * PROD_W'(SINE_TABLE_DEPTH);
  assign addr     = quadrant[0] ? IDX_W'(SINE_TABLE_DEPTH) - idx : idx;
  assign rounded  = scaled + SCL_W'(32768);
  assign sine_mag = rounded[SCL_W-1:16];
  assign peak_ext = VEL_W'(cfg.peak_velocity);

  always_comb begin
    unique case (cur.kind)
      rsrv_pkg::KIND_SINE: vel_sel = quadrant[1] ? -$signed(sine_mag) : $signed(sine_mag);
      rsrv_pkg::KIND_POS:  vel_sel = $signed(peak_ext);
      rsrv_pkg::KIND_NEG:  vel_sel = -$signed(peak_ext);
      rsrv_pkg::KIND_ZERO: vel_sel = '0;
      default:             vel_sel = '0;
    endcase
  end

  assign pop_ready = (state == B_IDLE);
  assign out_free  = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= B_IDLE;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        B_IDLE: begin
          if (pop_valid) begin
            cur   <= pop_data;
            state <= B_PHASE;
          end
        end
        B_PHASE: begin
          phase <= cur.arg * cfg.phase_rate;
          state <= B_INDEX;
        end
        B_INDEX: begin
          quadrant <= phase[31:30];
          idx      <= idx_prod[PROD_W-1:30];
          state    <= B_READ;
        end
        B_READ: begin
          mag   <= quarter_wave[addr];
          state <= B_SCALE;
        end
        B_SCALE: begin
          scaled <= SCL_W'(cfg.peak_velocity) * SCL_W'(mag);
          state  <= B_DONE;
        end
        B_DONE: begin
          if (out_free) begin
            velocity_x   <= vel_sel;
            finished     <= cur.finished;
            sweeps_done  <= cur.count;
            result_valid <= 1'b1;
            state        <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

// File: sv/reciprocating_sine_ramp_velocity.sv
// channel   direction  handshake                      payload
// item      in         item_valid / item_ready        action, period_us
// result    out        result_valid / result_ready    velocity_x, finished, sweeps_done
// config    in         psel, penable, pwrite, pready  paddr, pwdata, prdata
//
// an item passes through three front states (accept, classify, queue write) and
// six back sequencer states (dequeue, phase multiply, table index, table read,
// scale, output); the back takes no new item until it has output the last one,
// so the back sequencer sets the rate
// reset clears time, sweep count, registers and all handshake state
// a stalled result holds the back only; the two-entry queue lets the front
// keep taking items until it fills
module reciprocating_sine_ramp_velocity #(
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  logic                              clk,
  input  logic                              rst,
  // item channel
  input  logic                              item_valid,
  output logic                              item_ready,
  input  logic                              action,
  input  logic [15:0]                       period_us,
  // result channel
  output logic                              result_valid,
  input  logic                              result_ready,
  output logic signed [rsrv_pkg::VEL_W-1:0] velocity_x,
  output logic                              finished,
  output logic [rsrv_pkg::COUNT_W-1:0]      sweeps_done,
  // config port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [4:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  rsrv_pkg::cfg_t   cfg;
  logic             cfg_write;
  logic [2:0]       reg_index;

  logic             push_valid;
  logic             push_ready;
  rsrv_pkg::entry_t push_data;
  logic             pop_valid;
  logic             pop_ready;
  rsrv_pkg::entry_t pop_data;

  // word-addressed registers, index in bits 4..2
  assign pready    = 1'b1;
  assign reg_index = paddr[4:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      unique case (reg_index)
        rsrv_pkg::REG_PEAK_VELOCITY:  cfg.peak_velocity  <= pwdata[19:0];
        rsrv_pkg::REG_PHASE_RATE:     cfg.phase_rate     <= pwdata;
        rsrv_pkg::REG_RAMP_TIME:      cfg.ramp_time      <= pwdata;
        rsrv_pkg::REG_CONSTANT_TIME:  cfg.constant_time  <= $signed(pwdata);
        rsrv_pkg::REG_CYCLE_LIMIT:    cfg.cycle_limit    <= pwdata[15:0];
        rsrv_pkg::REG_SWEEP_DISTANCE: cfg.sweep_distance <= pwdata[23:0];
        rsrv_pkg::REG_RAMP_DISTANCE:  cfg.ramp_distance  <= pwdata[23:0];
        default: ;  // writes past the register list are dropped
      endcase
    end
  end

  // readback, zero-extended
  always_comb begin
    unique case (reg_index)
      rsrv_pkg::REG_PEAK_VELOCITY:  prdata = 32'(cfg.peak_velocity);
      rsrv_pkg::REG_PHASE_RATE:     prdata = cfg.phase_rate;
      rsrv_pkg::REG_RAMP_TIME:      prdata = cfg.ramp_time;
      rsrv_pkg::REG_CONSTANT_TIME:  prdata = $unsigned(cfg.constant_time);
      rsrv_pkg::REG_CYCLE_LIMIT:    prdata = 32'(cfg.cycle_limit);
      rsrv_pkg::REG_SWEEP_DISTANCE: prdata = 32'(cfg.sweep_distance);
      rsrv_pkg::REG_RAMP_DISTANCE:  prdata = 32'(cfg.ramp_distance);
      default:                      prdata = '0;
    endcase
  end

  // front: time counter, wrap, segment choice
  rsrv_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .action     (action),
    .period_us  (period_us),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // classified items waiting for the back
  rsrv_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // back: phase multiply, quarter-wave lookup, scale by peak velocity
  rsrv_back #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .pop_valid    (pop_valid),
    .pop_ready    (pop_ready),
    .pop_data     (pop_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .velocity_x   (velocity_x),
    .finished     (finished),
    .sweeps_done  (sweeps_done)
  );

  // checks
  logic signed [rsrv_pkg::VEL_W-1:0] peak_s;
  assign peak_s = $signed({1'b0, cfg.peak_velocity});

  // sine scaling never exceeds the peak speed
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (velocity_x <= peak_s) && (velocity_x >= -peak_s))
    else $error("velocity beyond peak");

  // a sweep no longer than the ramp always finishes
  assert property (@(posedge clk) disable iff (rst)
    result_valid && (cfg.sweep_distance <= cfg.ramp_distance) |-> finished)
    else $error("short sweep not finished");

  // reaching the sweep limit always finishes
  assert property (@(posedge clk) disable iff (rst)
    result_valid && (sweeps_done >= cfg.cycle_limit) |-> finished)
    else $error("sweep limit not finished");

endmodule

// File: bench/reciprocating_sine_ramp_velocity_tb.sv
module reciprocating_sine_ramp_velocity_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH = 256;
  localparam longint unsigned TIME_MAX = (64'd1 << rsrv_pkg::TIME_W) - 64'd1;
  // cycles allowed for an item to clear the pipe once the last result is in
  localparam int SETTLE_CYCLES = 16;

  // one expected result item
  typedef struct {
    logic signed [rsrv_pkg::VEL_W-1:0] velocity;
    logic                              finished;
    logic [rsrv_pkg::COUNT_W-1:0]      sweeps;
  } sweep_sample_t;

  // velocity profile predictor plus the queue of results still owed by the block
  class sweep_scoreboard;
    int               quarter_wave [TABLE_DEPTH+1];
    rsrv_pkg::cfg_t   cfg;
    longint unsigned  elapsed;
    logic [15:0]      sweep_count;
    sweep_sample_t    expected_samples [$];
    int               failures;

    function new();
      for (int k = 0; k <= TABLE_DEPTH; k++) begin
        quarter_wave[k] = table_entry(k);
      end
      cfg = '0;
      elapsed = 0;
      sweep_count = '0;
      failures = 0;
    endfunction

    // q16 quarter-wave entry from a q30 taylor series of sin
    function int table_entry(int k);
      longint unsigned x, x2, term;
      longint sum, q;
      x = (rsrv_pkg::HALF_PI_Q30 * longint'(k)) / TABLE_DEPTH;
      x2 = (x * x) >> 30;
      term = x;
      sum = longint'(x);
      for (int n = 1; n <= 13; n++) begin
        term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) sum -= longint'(term);
        else sum += longint'(term);
      end
      if (sum < 0) sum = 0;
      q = (sum + 8192) >>> 14;
      if (q > 65536) q = 65536;
      return int'(q);
    endfunction

    function void set_register(logic [2:0] index, logic [31:0] value);
      case (index)
        rsrv_pkg::REG_PEAK_VELOCITY:  cfg.peak_velocity  = value[19:0];
        rsrv_pkg::REG_PHASE_RATE:     cfg.phase_rate     = value;
        rsrv_pkg::REG_RAMP_TIME:      cfg.ramp_time      = value;
        rsrv_pkg::REG_CONSTANT_TIME:  cfg.constant_time  = value;
        rsrv_pkg::REG_CYCLE_LIMIT:    cfg.cycle_limit    = value[15:0];
        rsrv_pkg::REG_SWEEP_DISTANCE: cfg.sweep_distance = value[23:0];
        rsrv_pkg::REG_RAMP_DISTANCE:  cfg.ramp_distance  = value[23:0];
        default: ;
      endcase
    endfunction

    // sweep period 4A + 2C, signed
    function longint sweep_period();
      return 4 * longint'(cfg.ramp_time) + 2 * longint'($signed(cfg.constant_time));
    endfunction

    // peak * sin(omega * arg), phase wraps at one turn
    function longint sine_velocity(longint arg);
      logic [31:0] phase;
      longint idx, v;
      int mag;
      phase = arg[31:0] * cfg.phase_rate;
      idx = (longint'(phase[29:0]) * TABLE_DEPTH) >> 30;
      if (idx > TABLE_DEPTH) idx = TABLE_DEPTH;
      mag = phase[30] ? quarter_wave[TABLE_DEPTH - idx] : quarter_wave[idx];
      v = (longint'(cfg.peak_velocity) * mag + 32768) >> 16;
      return phase[31] ? -v : v;
    endfunction

    function void note_item(logic act, logic [15:0] period);
      sweep_sample_t s;
      longint a, c, total, t, vel;
      vel = 0;
      if (act) begin
        elapsed = 0;
      end else begin
        a = longint'(cfg.ramp_time);
        c = longint'($signed(cfg.constant_time));
        total = sweep_period();
        elapsed += period;
        if (elapsed > TIME_MAX) elapsed = TIME_MAX;
        t = longint'(elapsed);
        if (t <= a) vel = sine_velocity(t);
        else if (t <= c + a) vel = longint'(cfg.peak_velocity);
        else if (t <= c + 3 * a) vel = sine_velocity(t - c);
        else if (t <= total - a) vel = -longint'(cfg.peak_velocity);
        else vel = sine_velocity(t - 2 * c);
        if (t >= total) begin
          elapsed = (total <= 0) ? 0 : t - total;
          if (sweep_count != 16'hFFFF) sweep_count++;
        end
      end
      s.velocity = vel[rsrv_pkg::VEL_W-1:0];
      s.finished = (cfg.sweep_distance <= cfg.ramp_distance) ||
                   (sweep_count >= cfg.cycle_limit);
      s.sweeps = sweep_count;
      expected_samples.push_back(s);
    endfunction

    function void check_result(logic signed [rsrv_pkg::VEL_W-1:0] vel, logic fin,
                               logic [rsrv_pkg::COUNT_W-1:0] sweeps);
      sweep_sample_t s;
      if (expected_samples.size() == 0) begin
        $error("result with nothing outstanding: velocity_x %0d", vel);
        failures++;
        return;
      end
      s = expected_samples.pop_front();
      if (vel !== s.velocity) begin
        $error("velocity_x: expected %0d, actual %0d", s.velocity, vel);
        failures++;
      end
      if (fin !== s.finished) begin
        $error("finished: expected %0b, actual %0b", s.finished, fin);
        failures++;
      end
      if (sweeps !== s.sweeps) begin
        $error("sweeps_done: expected %0d, actual %0d", s.sweeps, sweeps);
        failures++;
      end
    endfunction

    function int pending();
      return expected_samples.size();
    endfunction
  endclass

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              item_valid = 1'b0;
  logic                              item_ready;
  logic                              action = 1'b0;
  logic [15:0]                       period_us = '0;
  logic                              result_valid;
  logic                              result_ready = 1'b0;
  logic signed [rsrv_pkg::VEL_W-1:0] velocity_x;
  logic                              finished;
  logic [rsrv_pkg::COUNT_W-1:0]      sweeps_done;
  logic                              psel = 1'b0;
  logic                              penable = 1'b0;
  logic                              pwrite = 1'b0;
  logic [4:0]                        paddr = '0;
  logic [31:0]                       pwdata = '0;
  logic [31:0]                       prdata;
  logic                              pready;

  sweep_scoreboard sb;

  // hold_request: asks the receiver for one long hold-off
  bit hold_request = 1'b0;
  int burst_left = 0;

  reciprocating_sine_ramp_velocity #(.SINE_TABLE_DEPTH(TABLE_DEPTH)) dut (.*);

  always #6 clk = ~clk;

  // both channels are sampled here, on the same edge the block sees
  always @(posedge clk) begin
    if (!rst) begin
      if (item_valid && item_ready) sb.note_item(action, period_us);
      if (result_valid && result_ready) sb.check_result(velocity_x, finished, sweeps_done);
    end
  end

  // receiver: stretches of random length, each with its own stall pattern;
  // one long hold-off on request so the block fills and stops taking items
  initial begin : receiver
    int mode, stretch;
    forever begin
      mode = $urandom_range(0, 3);
      stretch = $urandom_range(10, 150);
      for (int k = 0; k < stretch; k++) begin
        @(posedge clk);
        if (hold_request) begin
          result_ready <= 1'b0;
          repeat (400) @(posedge clk);
          hold_request = 1'b0;
        end else begin
          case (mode)
            0: result_ready <= 1'b1;
            1: result_ready <= 1'($urandom_range(0, 1));
            2: result_ready <= ($urandom_range(0, 3) == 0);
            default: result_ready <= (k % 8) < 5;
          endcase
        end
      end
    end
  end

  // config write: setup cycle, access cycle, then idle
  task automatic apb_write(logic [2:0] index, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {index, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_register(index, value);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_profile(logic [31:0] peak, logic [31:0] rate, logic [31:0] ramp,
                               logic [31:0] ctime, logic [31:0] limit,
                               logic [31:0] sweep, logic [31:0] rdist);
    apb_write(rsrv_pkg::REG_PEAK_VELOCITY, peak);
    apb_write(rsrv_pkg::REG_PHASE_RATE, rate);
    apb_write(rsrv_pkg::REG_RAMP_TIME, ramp);
    apb_write(rsrv_pkg::REG_CONSTANT_TIME, ctime);
    apb_write(rsrv_pkg::REG_CYCLE_LIMIT, limit);
    apb_write(rsrv_pkg::REG_SWEEP_DISTANCE, sweep);
    apb_write(rsrv_pkg::REG_RAMP_DISTANCE, rdist);
  endtask

  // bursts of random length with random gaps, long gaps now and then
  task automatic push(logic act, logic [15:0] period);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 7);
      if (gap > 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    item_valid <= 1'b1;
    action <= act;
    period_us <= period;
    do @(posedge clk); while (!item_ready);
  endtask

  // stop offering, wait for every owed result, then let the pipe settle
  task automatic drain();
    item_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // random profile: mostly sensible sweeps, sometimes raw register values;
  // constant time may go negative enough to make the period non-positive
  task automatic random_profile();
    logic [31:0] peak, rate, ramp, ctime, limit, sweep, rdist;
    int          choice, lim;
    choice = $urandom_range(0, 5);
    if (choice == 0) begin
      ramp = $urandom;
      ctime = $urandom;
    end else begin
      ramp = (choice == 1) ? $urandom_range(0, 3) : $urandom_range(1, 20000);
      case ($urandom_range(0, 2))
        0: ctime = -$urandom_range(0, 2 * ramp + 2);
        1: ctime = $urandom_range(0, 3 * ramp);
        default: ctime = $urandom_range(0, 50);
      endcase
    end
    // about a quarter turn over the ramp keeps the sine shape readable
    rate = ($urandom_range(0, 2) != 0 && ramp != 0) ? 32'h4000_0000 / ramp : $urandom;
    case ($urandom_range(0, 5))
      0: peak = $urandom;
      1: peak = 0;
      2: peak = 32'h000F_FFFF;
      default: peak = $urandom_range(0, 1000000);
    endcase
    // limit near the current count so finished flips during the phase
    lim = int'(sb.sweep_count) + $urandom_range(0, 6);
    if (lim > 65535) lim = 65535;
    limit = $urandom_range(0, 1) ? lim : $urandom_range(0, 65535);
    sweep = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1000, 2000000);
    rdist = ($urandom_range(0, 3) == 0) ? sweep : $urandom_range(0, 1500000);
    write_profile(peak, rate, ramp, ctime, limit, sweep, rdist);
  endtask

  // ticks sized to walk through the segments, plus restarts and extremes
  task automatic random_tick();
    longint      span;
    logic        act;
    logic [15:0] period;
    span = sb.sweep_period() / 24;
    if (sb.sweep_period() <= 0 || span > 65535) span = 65535;
    if (span < 1) span = 1;
    act = ($urandom_range(0, 19) == 0);
    case ($urandom_range(0, 9))
      0: period = 16'($urandom);
      1: period = '0;
      2: period = 16'hFFFF;
      default: period = 16'($urandom_range(0, int'(span)));
    endcase
    push(act, period);
  endtask

  initial begin : stimulus
    sb = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // five segments with A = 1000, C = 500, T = 5000, hitting each boundary
    write_profile(1000000, 32'h4000_0000 / 1000, 1000, 500, 2, 5000, 1000);
    push(1'b1, 16'd0);
    push(1'b0, 16'd0);
    push(1'b0, 16'd250);
    push(1'b0, 16'd750);
    push(1'b0, 16'd1);
    push(1'b0, 16'd499);
    push(1'b0, 16'd1);
    push(1'b0, 16'd999);
    push(1'b0, 16'd1000);
    push(1'b0, 16'd1);
    push(1'b0, 16'd499);
    push(1'b0, 16'd500);
    // lands exactly on the period: wrap to zero
    push(1'b0, 16'd500);
    // far past the period: only one wrap per tick
    push(1'b0, 16'hFFFF);
    push(1'b0, 16'd0);
    push(1'b1, 16'hFFFF);
    drain();

    // negative period: every tick that is not a restart wraps to zero; peak register written all ones
    write_profile(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, -5, 0, 0, 32'h00FF_FFFF);
    push(1'b0, 16'd7);
    push(1'b0, 16'hFFFF);
    push(1'b1, 16'd0);
    push(1'b0, 16'd0);
    drain();

    // negative constant time, overlapping segments
    write_profile(777777, 32'h4000_0000 / 1000, 1000, -300, 16'hFFFF, 24'hFF_FFFF, 0);
    push(1'b0, 16'd800);
    push(1'b0, 16'd400);
    push(1'b0, 16'd1000);
    push(1'b0, 16'd1500);
    drain();

    // random phases, one of them under a long receiver hold-off
    for (int ph = 0; ph < 8; ph++) begin
      random_profile();
      if (ph == 3) hold_request = 1'b1;
      for (int i = 0; i < 106; i++) random_tick();
      drain();
    end

    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog, several times the slowest legal run
  initial begin : watchdog
    #3ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
